### rtl/pfm_pkg.sv
// shared types and constants of the polled frame master
package pfm_pkg;

   localparam logic [7:0] FRAME_START = 8'hAA;
   localparam logic [7:0] FRAME_END   = 8'h55;
   localparam logic [7:0] ACK_CODE    = 8'hAC;
   localparam logic [7:0] FIN_CODE    = 8'hFF;

   localparam logic [15:0] POLL_PERIOD_RESET    = 16'd5000;
   localparam logic [15:0] SUSPEND_PERIOD_RESET = 16'd60000;

   // event kinds
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_BUTTON = 2'd1;
   localparam logic [1:0] OP_RX     = 2'd2;

   // register indexes
   localparam logic REG_POLL    = 1'b0;
   localparam logic REG_SUSPEND = 1'b1;

   typedef struct packed {
      logic [15:0] poll_period;
      logic [15:0] suspend_period;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] mid;
   } frame_req_type;

endpackage

### rtl/pfm_if.sv
// valid/ready channels of the request and response sides
interface pfm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] rx_byte;
   logic [7:0] slave_addr;
   logic [7:0] slave_cmd;

   modport source (output valid, output operation, output rx_byte,
                   output slave_addr, output slave_cmd, input ready);
   modport sink   (input valid, input operation, input rx_byte,
                   input slave_addr, input slave_cmd, output ready);
endinterface

interface pfm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       tx_last;

   modport source (output valid, output tx_byte, output tx_last, input ready);
   modport sink   (input valid, input tx_byte, input tx_last, output ready);
endinterface

### rtl/pfm_ctrl.sv
// event handling, ack parser and poll controller state
module pfm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  pfm_pkg::cfg_type       cfg,
   input  logic                   accept,
   input  logic [1:0]             operation,
   input  logic [7:0]             rx_byte,
   input  logic [7:0]             slave_addr,
   input  logic [7:0]             slave_cmd,
   output pfm_pkg::frame_req_type frame
);

   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_WAIT1   = 2'd1;
   localparam logic [1:0] MODE_WAIT2   = 2'd2;
   localparam logic [1:0] MODE_SUSPEND = 2'd3;

   localparam logic [1:0] PARSE_HUNT = 2'd0;
   localparam logic [1:0] PARSE_MID  = 2'd1;
   localparam logic [1:0] PARSE_END  = 2'd2;

   logic [1:0]  mode_ff, mode_in;
   logic [15:0] count_ff, count_in;
   logic        ack_ff, ack_in;
   logic [1:0]  pidx_ff, pidx_in;
   logic [7:0]  mid_ff, mid_in;
   logic [7:0]  held_ff, held_in;
   logic [15:0] count_inc;
   logic        tick;

   assign tick      = (operation == pfm_pkg::OP_TICK);
   assign count_inc = count_ff + 16'd1;

   always_comb begin
      mode_in     = mode_ff;
      count_in    = count_ff;
      ack_in      = ack_ff;
      pidx_in     = pidx_ff;
      mid_in      = mid_ff;
      held_in     = held_ff;
      frame.valid = 1'b0;
      frame.mid   = pfm_pkg::FIN_CODE;
      if (operation == pfm_pkg::OP_BUTTON) begin
         mode_in  = MODE_SUSPEND;
         count_in = '0;
         pidx_in  = PARSE_HUNT;
         mid_in   = '0;
         ack_in   = 1'b0;
      end else begin
         // parse first so an ack completed by this byte is seen by the step
         if (operation == pfm_pkg::OP_RX && mode_ff != MODE_SUSPEND) begin
            case (pidx_ff)
               PARSE_MID: begin
                  mid_in  = rx_byte;
                  pidx_in = PARSE_END;
               end
               PARSE_END: begin
                  pidx_in = PARSE_HUNT;
                  if (rx_byte == pfm_pkg::FRAME_END && mid_ff == pfm_pkg::ACK_CODE)
                     ack_in = 1'b1;
               end
               default: begin
                  pidx_in = (rx_byte == pfm_pkg::FRAME_START) ? PARSE_MID : PARSE_HUNT;
               end
            endcase
         end
         case (mode_ff)
            MODE_IDLE: begin
               if (tick) begin
                  count_in = count_inc;
                  if (count_inc >= cfg.poll_period) begin
                     count_in    = '0;
                     held_in     = slave_cmd;
                     mode_in     = MODE_WAIT1;
                     frame.valid = 1'b1;
                     frame.mid   = slave_addr;
                  end
               end
            end
            MODE_WAIT1: begin
               if (ack_in) begin
                  ack_in      = 1'b0;
                  mode_in     = MODE_WAIT2;
                  frame.valid = 1'b1;
                  frame.mid   = held_ff;
               end
            end
            MODE_WAIT2: begin
               if (ack_in) begin
                  ack_in      = 1'b0;
                  count_in    = '0;
                  mode_in     = MODE_IDLE;
                  frame.valid = 1'b1;
                  frame.mid   = pfm_pkg::FIN_CODE;
               end
            end
            default: begin
               if (tick) begin
                  count_in = count_inc;
                  if (count_inc >= cfg.suspend_period) begin
                     mode_in  = MODE_IDLE;
                     count_in = '0;
                     pidx_in  = PARSE_HUNT;
                     mid_in   = '0;
                  end
               end
            end
         endcase
      end
      if (!accept)
         frame.valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= '0;
         ack_ff   <= 1'b0;
         pidx_ff  <= PARSE_HUNT;
         mid_ff   <= '0;
         held_ff  <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         ack_ff   <= ack_in;
         pidx_ff  <= pidx_in;
         mid_ff   <= mid_in;
         held_ff  <= held_in;
      end
   end

endmodule

### rtl/pfm_tx.sv
// frame serializer with one waiting frame slot
module pfm_tx (
   input  logic                   clock,
   input  logic                   reset,
   input  pfm_pkg::frame_req_type frame,
   output logic                   can_take,
   pfm_rsp_if.source              rsp
);

   localparam logic [1:0] POS_START = 2'd0;
   localparam logic [1:0] POS_MID   = 2'd1;
   localparam logic [1:0] POS_END   = 2'd2;

   logic       cur_valid_ff, cur_valid_in;
   logic [7:0] cur_mid_ff, cur_mid_in;
   logic [1:0] pos_ff, pos_in;
   logic       pend_valid_ff, pend_valid_in;
   logic [7:0] pend_mid_ff, pend_mid_in;
   logic       moved;
   logic       cur_free;

   assign can_take = !pend_valid_ff;
   assign moved    = cur_valid_ff && rsp.ready;
   assign cur_free = !cur_valid_ff || (moved && pos_ff == POS_END);

   assign rsp.valid   = cur_valid_ff;
   assign rsp.tx_last = (pos_ff == POS_END);

   always_comb begin
      case (pos_ff)
         POS_START: rsp.tx_byte = pfm_pkg::FRAME_START;
         POS_MID:   rsp.tx_byte = cur_mid_ff;
         default:   rsp.tx_byte = pfm_pkg::FRAME_END;
      endcase
   end

   always_comb begin
      cur_valid_in  = cur_valid_ff;
      cur_mid_in    = cur_mid_ff;
      pos_in        = pos_ff;
      pend_valid_in = pend_valid_ff;
      pend_mid_in   = pend_mid_ff;
      if (cur_free) begin
         pos_in = POS_START;
         if (pend_valid_ff) begin
            cur_valid_in  = 1'b1;
            cur_mid_in    = pend_mid_ff;
            pend_valid_in = frame.valid;
            pend_mid_in   = frame.mid;
         end else begin
            cur_valid_in = frame.valid;
            cur_mid_in   = frame.mid;
         end
      end else begin
         if (moved)
            pos_in = pos_ff + 2'd1;
         if (frame.valid) begin
            pend_valid_in = 1'b1;
            pend_mid_in   = frame.mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         pos_ff        <= POS_START;
      end else begin
         cur_valid_ff  <= cur_valid_in;
         pend_valid_ff <= pend_valid_in;
         pos_ff        <= pos_in;
      end
      cur_mid_ff  <= cur_mid_in;
      pend_mid_ff <= pend_mid_in;
   end

endmodule

### rtl/polled_frame_master_with_ack.sv
// polled frame master: event handling, frame output and register port
// an event's state update happens at its accepting edge; its frame is registered into the
// serializer (or the waiting slot while one drains) and goes out on rsp as three
// transactions (AA, middle byte, 55 with tx_last); events are taken every cycle while
// the waiting frame slot is empty; a frame queued behind a draining one holds req ready low
// synchronous reset returns to idle with cleared counters and periods 5000 / 60000
module polled_frame_master_with_ack (
   input  logic        clock,
   input  logic        reset,
   pfm_req_if.sink     req_bus,
   pfm_rsp_if.source   rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   pfm_pkg::cfg_type       cfg_ff;
   pfm_pkg::frame_req_type frame;
   logic                   can_take;
   logic                   accept;
   logic                   wr_en;

   assign pready        = 1'b1;
   assign wr_en         = psel && penable && pwrite;
   assign req_bus.ready = can_take;
   assign accept        = req_bus.valid && can_take;

   always_comb begin
      case (paddr[2])
         pfm_pkg::REG_POLL: prdata = {16'd0, cfg_ff.poll_period};
         default:           prdata = {16'd0, cfg_ff.suspend_period};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poll_period    <= pfm_pkg::POLL_PERIOD_RESET;
         cfg_ff.suspend_period <= pfm_pkg::SUSPEND_PERIOD_RESET;
      end else if (wr_en) begin
         if (paddr[2] == pfm_pkg::REG_POLL)
            cfg_ff.poll_period <= pwdata[15:0];
         else
            cfg_ff.suspend_period <= pwdata[15:0];
      end
   end

   pfm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .operation  (req_bus.operation),
      .rx_byte    (req_bus.rx_byte),
      .slave_addr (req_bus.slave_addr),
      .slave_cmd  (req_bus.slave_cmd),
      .frame      (frame)
   );

   pfm_tx u_tx (
      .clock    (clock),
      .reset    (reset),
      .frame    (frame),
      .can_take (can_take),
      .rsp      (rsp_bus)
   );

endmodule
